FILE: rtl/sed_pkg.sv
// Shared types, character codes and decode helpers for the string escape decoder.
package sed_pkg;

  localparam int QueueDepthDef = 2;

  localparam logic [7:0] ChrNul       = 8'h00;
  localparam logic [7:0] ChrBackslash = 8'h5C;
  localparam logic [7:0] ChrX         = 8'h78;
  localparam logic [7:0] ChrZero      = 8'h30;
  localparam logic [7:0] ChrNine      = 8'h39;
  localparam logic [7:0] ChrLowA      = 8'h61;
  localparam logic [7:0] ChrLowF      = 8'h66;
  localparam logic [7:0] ChrUpA       = 8'h41;
  localparam logic [7:0] ChrUpF       = 8'h46;
  localparam logic [7:0] ChrR         = 8'h72;
  localparam logic [7:0] ChrA         = 8'h61;
  localparam logic [7:0] ChrB         = 8'h62;
  localparam logic [7:0] ChrE         = 8'h65;
  localparam logic [7:0] ChrN         = 8'h6E;
  localparam logic [7:0] ChrT         = 8'h74;

  localparam logic [7:0] CodeCr  = 8'd13;
  localparam logic [7:0] CodeBel = 8'd7;
  localparam logic [7:0] CodeBs  = 8'd8;
  localparam logic [7:0] CodeEsc = 8'd27;
  localparam logic [7:0] CodeLf  = 8'd10;
  localparam logic [7:0] CodeTab = 8'd9;

  typedef enum logic [4:0] {
    MODE_NORMAL = 5'b00001,
    MODE_ESCAPE = 5'b00010,
    MODE_HEX    = 5'b00100,
    MODE_OCTAL  = 5'b01000,
    MODE_DONE   = 5'b10000
  } mode_t;

  // A pushed command carries one or two results; has0 low marks an end marker.
  typedef struct packed {
    logic [7:0] data0;
    logic       has0;
    logic       two;
    logic [7:0] data1;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t head;
  } q_stat_t;

  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b inside {[ChrZero:ChrNine]}) begin
      r = {1'b1, b[3:0]};
    end else if (b inside {[ChrLowA:ChrLowF], [ChrUpA:ChrUpF]}) begin
      r = {1'b1, b[3:0] + 4'd9};
    end
    return r;
  endfunction

  function automatic logic [7:0] control_code(input logic [7:0] b);
    logic [7:0] r;
    case (b)
      ChrR:    r = CodeCr;
      ChrA:    r = CodeBel;
      ChrB:    r = CodeBs;
      ChrE:    r = CodeEsc;
      ChrN:    r = CodeLf;
      ChrT:    r = CodeTab;
      default: r = b;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/sed_front.sv
// Front end: accepts raw bytes, tracks the escape state and builds result commands.
module sed_front import sed_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  input  logic       q_full,
  output logic       in_stall,
  output logic       push,
  output cmd_t       cmd
);

  mode_t       mode_r, mode_nxt;
  logic [7:0]  acc_r, acc_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        accept;
  logic [4:0]  hx;
  logic        is_dig;
  logic        p_emit;
  mode_t       p_mode;
  logic        a_v, b_v, f_v;
  logic [7:0]  a_d, b_d, f_d;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    hx      = hex_digit(in_byte);
    is_dig  = in_byte inside {[ChrZero:ChrNine]};
    p_emit  = (in_byte != ChrNul) && (in_byte != ChrBackslash);
    p_mode  = (in_byte == ChrNul) ? MODE_DONE :
              (in_byte == ChrBackslash) ? MODE_ESCAPE : MODE_NORMAL;
    mode_nxt = mode_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    a_v = 1'b0;
    a_d = 8'd0;
    b_v = 1'b0;
    b_d = 8'd0;
    case (mode_r)
      MODE_NORMAL: begin
        mode_nxt = p_mode;
        a_v      = p_emit;
        a_d      = in_byte;
      end
      MODE_ESCAPE: begin
        if (in_byte == ChrX) begin
          mode_nxt = MODE_HEX;
          acc_nxt  = 8'd0;
          cnt_nxt  = 2'd0;
        end else if (is_dig) begin
          mode_nxt = MODE_OCTAL;
          acc_nxt  = {4'd0, in_byte[3:0]};
          cnt_nxt  = 2'd1;
        end else begin
          mode_nxt = MODE_NORMAL;
          a_v      = 1'b1;
          a_d      = control_code(in_byte);
        end
      end
      MODE_HEX: begin
        if (hx[4]) begin
          acc_nxt = {acc_r[3:0], hx[3:0]};
          cnt_nxt = cnt_r + 2'd1;
          if (cnt_r == 2'd1) begin
            mode_nxt = MODE_NORMAL;
            a_v      = 1'b1;
            a_d      = acc_nxt;
          end
        end else begin
          mode_nxt = p_mode;
          a_v      = 1'b1;
          a_d      = acc_r;
          b_v      = p_emit;
          b_d      = in_byte;
        end
      end
      MODE_OCTAL: begin
        if (is_dig) begin
          acc_nxt = {acc_r[4:0], 3'b000} + {4'd0, in_byte[3:0]};
          cnt_nxt = cnt_r + 2'd1;
          if (cnt_r == 2'd2) begin
            mode_nxt = MODE_NORMAL;
            a_v      = 1'b1;
            a_d      = acc_nxt;
          end
        end else begin
          mode_nxt = p_mode;
          a_v      = 1'b1;
          a_d      = acc_r;
          b_v      = p_emit;
          b_d      = in_byte;
        end
      end
      MODE_DONE: begin
        mode_nxt = MODE_DONE;
      end
      default: begin
        mode_nxt = MODE_DONE;
      end
    endcase

    f_v = (mode_nxt == MODE_ESCAPE) || (mode_nxt == MODE_HEX) || (mode_nxt == MODE_OCTAL);
    f_d = (mode_nxt == MODE_ESCAPE) ? 8'd0 : acc_nxt;
    if (in_last) begin
      if (f_v) begin
        if (!a_v) begin
          a_v = 1'b1;
          a_d = f_d;
        end else begin
          b_v = 1'b1;
          b_d = f_d;
        end
      end
      mode_nxt = MODE_NORMAL;
      acc_nxt  = 8'd0;
      cnt_nxt  = 2'd0;
    end

    push      = accept && (a_v || in_last);
    cmd.data0 = a_v ? a_d : 8'd0;
    cmd.has0  = a_v;
    cmd.two   = b_v;
    cmd.data1 = b_d;
    cmd.last  = in_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_NORMAL;
      acc_r  <= 8'd0;
      cnt_r  <= 2'd0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      acc_r  <= acc_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

FILE: rtl/sed_queue.sv
// Command queue that decouples the front end from the output sequencer.
module sed_queue import sed_pkg::*; #(
  parameter int DEPTH = QueueDepthDef
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  cmd_t    cmd_in,
  input  logic    pop,
  output logic    full,
  output q_stat_t stat
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  cmd_t            mem_r [DEPTH];
  logic [PtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0] cnt_r, cnt_nxt;

  assign full       = cnt_r == CntW'(DEPTH);
  assign stat.valid = cnt_r != '0;
  assign stat.head  = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + CntW'(1);
      2'b01:   cnt_nxt = cnt_r - CntW'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + PtrW'(1);
      end
    end
  end

endmodule

FILE: rtl/sed_back.sv
// Back end: plays out queued commands one result per transfer and keeps the length count.
module sed_back import sed_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  q_stat_t     stat,
  output logic        pop,
  input  logic        out_stall,
  output logic        out_valid,
  output logic [7:0]  out_byte,
  output logic        out_has_data,
  output logic        out_last,
  output logic [15:0] out_length
);

  logic        out_valid_r;
  logic [7:0]  out_byte_r;
  logic        out_has_r;
  logic        out_last_r;
  logic [15:0] out_len_r;
  logic        phase_r;
  logic [15:0] len_r, len_nxt;
  logic        load, emit;
  logic [7:0]  sel_d;
  logic        sel_h, sel_last;

  assign load     = !out_valid_r || !out_stall;
  assign emit     = stat.valid && load;
  assign sel_d    = phase_r ? stat.head.data1 : stat.head.data0;
  assign sel_h    = phase_r || stat.head.has0;
  assign sel_last = stat.head.last && (phase_r || !stat.head.two);
  assign pop      = emit && (phase_r || !stat.head.two);
  assign len_nxt  = (sel_h && (len_r != 16'hFFFF)) ? len_r + 16'd1 : len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      phase_r     <= 1'b0;
      len_r       <= 16'd0;
    end else begin
      if (load) begin
        out_valid_r <= emit;
      end
      if (emit) begin
        phase_r <= !pop;
        len_r   <= sel_last ? 16'd0 : len_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte_r <= sel_d;
      out_has_r  <= sel_h;
      out_last_r <= sel_last;
      out_len_r  <= len_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_byte     = out_byte_r;
  assign out_has_data = out_has_r;
  assign out_last     = out_last_r;
  assign out_length   = out_len_r;

endmodule

FILE: rtl/string_escape_decoder.sv
// Top level of the C-style string escape decoder.
//
//   Channel | Direction | Handshake          | Payload
//   in_     | input     | in_valid/in_stall  | in_byte, in_last
//   out_    | output    | out_valid/out_stall| out_byte, out_has_data, out_last, out_length
//
// A byte is taken every cycle while the command queue has room; it gives zero to two results.
// The output register delivers one result per cycle while out_stall is low; a byte with two results gives them in turn.
// The first result of an input transfer passes through the command queue and then the output register.
// Reset is synchronous; it clears the escape state, the queue and the length count.
// A stall on the output fills the queue, and in_stall rises once it is full.
module string_escape_decoder import sed_pkg::*; #(
  parameter int QUEUE_DEPTH = QueueDepthDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_has_data,
  output logic        out_last,
  output logic [15:0] out_length
);

  logic    q_full, push, pop;
  cmd_t    cmd;
  q_stat_t stat;

  sed_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .q_full   (q_full),
    .in_stall (in_stall),
    .push     (push),
    .cmd      (cmd)
  );

  sed_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .cmd_in (cmd),
    .pop    (pop),
    .full   (q_full),
    .stat   (stat)
  );

  sed_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .stat         (stat),
    .pop          (pop),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .out_byte     (out_byte),
    .out_has_data (out_has_data),
    .out_last     (out_last),
    .out_length   (out_length)
  );

endmodule

FILE: rtl/sed_checker.sv
// Port-level checker for the string escape decoder and its bind statement.
module sed_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_byte,
  input logic        out_has_data,
  input logic        out_last,
  input logic [15:0] out_length
);

  logic out_xfer;
  assign out_xfer = out_valid && !out_stall;

  // An end marker without data only appears as the final result of a string.
  a_marker_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_data |-> out_last)
    else $error("end marker without out_last");

  // A decoded byte always counts itself.
  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_has_data |-> out_length != 16'd0)
    else $error("data result with zero length");

  // Back-to-back transfers within a string advance the length by one per data byte.
  a_len_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(out_xfer) && !$past(out_last) && out_xfer && out_has_data |->
      (out_length == $past(out_length) + 16'd1) ||
      (($past(out_length) == 16'hFFFF) && (out_length == 16'hFFFF)))
    else $error("length did not advance by one");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_length) &&
      $stable(out_last) && $stable(out_has_data))
    else $error("stalled result changed");

endmodule

bind string_escape_decoder sed_checker u_sed_checker (.*);
